### design/sst_pkg.sv
package sst_pkg;

	// Table geometry. BUCKETS and WAYS are powers of two, so slot and row
	// numbers are plain concatenations of level, bucket and way.
	localparam int LEVELS  = 2;
	localparam int BUCKETS = 256;
	localparam int WAYS    = 4;
	localparam int ID_BITS = 16;

	localparam int LVL_W    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int BUCKET_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int ROWS     = LEVELS * BUCKETS;
	localparam int ROW_W    = LVL_W + BUCKET_W;

	localparam logic [2:0] KIND_LOOKUP_ALL = 3'd0;
	localparam logic [2:0] KIND_LOOKUP_ONE = 3'd1;
	localparam logic [2:0] KIND_INSTALL    = 3'd2;
	localparam logic [2:0] KIND_PUSH       = 3'd3;
	localparam logic [2:0] KIND_POP        = 3'd4;

	localparam logic [2:0] ERR_NONE  = 3'd0;
	localparam logic [2:0] ERR_DUP   = 3'd1;
	localparam logic [2:0] ERR_FULL  = 3'd2;
	localparam logic [2:0] ERR_OVER  = 3'd3;
	localparam logic [2:0] ERR_UNDER = 3'd4;
	localparam logic [2:0] ERR_SCOPE = 3'd5;

	typedef struct packed {
		logic               valid;
		logic [ID_BITS-1:0] ident;
		logic [5:0]         tclass;
		logic [7:0]         ttype;
	} entry_t;

	typedef entry_t [WAYS-1:0] row_t;

	typedef struct packed {
		logic        found;
		logic [7:0]  etype;
		logic [10:0] eslot;
		logic [2:0]  err;
	} res_t;

	typedef struct packed {
		logic             rd_en;
		logic [ROW_W-1:0] rd_addr;
		logic             wr_en;
		logic [ROW_W-1:0] wr_addr;
		row_t             wr_data;
	} mem_ctl_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_RD,
		ST_SWEEP,
		ST_DONE
	} state_t;

endpackage

### design/sst_if.sv
interface sst_cmd_if;
	logic       valid;
	logic       ready;
	logic [2:0] kind;
	logic [15:0] ident;
	logic [5:0] token_class;
	logic [7:0] token_type;
	logic [1:0] scope_sel;

	modport source (output valid, kind, ident, token_class, token_type, scope_sel,
		input ready);
	modport sink (input valid, kind, ident, token_class, token_type, scope_sel,
		output ready);
endinterface

interface sst_rsp_if;
	logic        valid;
	logic        ready;
	logic        found;
	logic [7:0]  entry_type;
	logic [10:0] entry_slot;
	logic [2:0]  error;
	logic        scope_level;

	modport source (output valid, found, entry_type, entry_slot, error, scope_level,
		input ready);
	modport sink (input valid, found, entry_type, entry_slot, error, scope_level,
		output ready);
endinterface

### design/scoped_symbol_table.sv
// A lookup or install goes through DISPATCH and one RD state per level searched, then DONE;
// push, pop errors, bad scope and unused kinds go straight to DONE; a pop first sweeps its level.
// Only one word is in flight: the next word is taken once the result is loaded into
// the output register, which DONE holds off while a result there waits on rsp.ready.
// Reset: level goes to 0 and a sweep of LEVELS*BUCKETS rows (512) clears the table,
// with cmd.ready low until it ends.
module scoped_symbol_table (
	input  logic            clk,
	input  logic            arst_n,
	sst_cmd_if.sink         cmd,
	sst_rsp_if.source       rsp
);
	import sst_pkg::*;

	// Table memory: one row per (level, bucket), all WAYS entries side by side,
	// each entry carrying its own valid bit. Row address is {level, bucket}.
	row_t mem [ROWS];
	row_t rd_row_q;

	state_t   state_q, state_d;
	logic [LVL_W-1:0] cur_q, cur_d;     // current scope level
	logic [LVL_W-1:0] lvl_q, lvl_d;     // level being searched
	logic [ROW_W-1:0] clr_q, clr_d;     // sweep row pointer
	res_t     res_q, res_d;
	mem_ctl_t mc;

	// item under work
	logic [2:0]  kind_q;
	logic [15:0] ident_q;
	logic [5:0]  class_q;
	logic [7:0]  type_q;
	logic [1:0]  sel_q;

	// output register
	logic        out_valid_q;
	res_t        out_res_q;
	logic        out_lvl_q;
	logic        out_load;
	logic        ready;

	logic [BUCKET_W-1:0] bucket;
	logic [WAYS-1:0]     hit_vec, free_vec;
	logic [WAY_W-1:0]    hit_way, free_way;
	row_t                new_row;

	assign bucket = ident_q[BUCKET_W-1:0];

	// Way compare on the row just read; lowest matching and lowest free way win.
	always_comb begin
		hit_way  = '0;
		free_way = '0;
		for (int w = 0; w < WAYS; w++) begin
			hit_vec[w]  = rd_row_q[w].valid && (rd_row_q[w].ident == ident_q[ID_BITS-1:0])
				&& (rd_row_q[w].tclass == class_q);
			free_vec[w] = !rd_row_q[w].valid;
		end
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (hit_vec[w])
				hit_way = WAY_W'(w);
			if (free_vec[w])
				free_way = WAY_W'(w);
		end
		new_row = rd_row_q;
		new_row[free_way] = '{valid: 1'b1, ident: ident_q[ID_BITS-1:0],
			tclass: class_q, ttype: type_q};
	end

	// Next state and memory control. Only one item is in flight, so a write
	// (install or sweep) never overlaps a read of the same row.
	always_comb begin
		state_d  = state_q;
		cur_d    = cur_q;
		lvl_d    = lvl_q;
		clr_d    = clr_q;
		res_d    = res_q;
		mc       = '0;
		ready    = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				mc.wr_en   = 1'b1;
				mc.wr_addr = clr_q;
				clr_d      = clr_q + 1'b1;
				if (clr_q == ROW_W'(ROWS - 1))
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				ready = 1'b1;
				if (cmd.valid)
					state_d = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				res_d   = '0;
				state_d = ST_DONE;
				unique case (kind_q)
					KIND_LOOKUP_ALL, KIND_INSTALL: begin
						lvl_d      = cur_q;
						mc.rd_en   = 1'b1;
						mc.rd_addr = {cur_q, bucket};
						state_d    = ST_RD;
					end
					KIND_LOOKUP_ONE: begin
						if (32'(sel_q) >= LEVELS) begin
							res_d.err = ERR_SCOPE;
						end else begin
							lvl_d      = sel_q[LVL_W-1:0];
							mc.rd_en   = 1'b1;
							mc.rd_addr = {sel_q[LVL_W-1:0], bucket};
							state_d    = ST_RD;
						end
					end
					KIND_PUSH: begin
						if (32'(cur_q) + 1 >= LEVELS)
							res_d.err = ERR_OVER;
						else
							cur_d = cur_q + 1'b1;
					end
					KIND_POP: begin
						if (cur_q == '0) begin
							res_d.err = ERR_UNDER;
						end else begin
							clr_d   = {cur_q, {BUCKET_W{1'b0}}};
							state_d = ST_SWEEP;
						end
					end
					default: ;
				endcase
			end
			ST_RD: begin
				state_d = ST_DONE;
				if (kind_q == KIND_INSTALL) begin
					if (|hit_vec) begin
						res_d.err   = ERR_DUP;
						res_d.etype = rd_row_q[hit_way].ttype;
						res_d.eslot = 11'({lvl_q, bucket, hit_way});
					end else if (!(|free_vec)) begin
						res_d.err = ERR_FULL;
					end else begin
						mc.wr_en    = 1'b1;
						mc.wr_addr  = {lvl_q, bucket};
						mc.wr_data  = new_row;
						res_d.found = 1'b1;
						res_d.etype = type_q;
						res_d.eslot = 11'({lvl_q, bucket, free_way});
					end
				end else if (|hit_vec) begin
					res_d.found = 1'b1;
					res_d.etype = rd_row_q[hit_way].ttype;
					res_d.eslot = 11'({lvl_q, bucket, hit_way});
				end else if (kind_q == KIND_LOOKUP_ALL && lvl_q != '0) begin
					// miss here: fall through to the next lower level
					lvl_d      = lvl_q - 1'b1;
					mc.rd_en   = 1'b1;
					mc.rd_addr = {lvl_q - 1'b1, bucket};
					state_d    = ST_RD;
				end
			end
			ST_SWEEP: begin
				mc.wr_en   = 1'b1;
				mc.wr_addr = clr_q;
				clr_d      = clr_q + 1'b1;
				if (clr_q[BUCKET_W-1:0] == {BUCKET_W{1'b1}}) begin
					cur_d   = cur_q - 1'b1;
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cur_q       <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cur_q   <= cur_d;
			clr_q   <= clr_d;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		lvl_q <= lvl_d;
		res_q <= res_d;
		if (state_q == ST_IDLE && cmd.valid) begin
			kind_q  <= cmd.kind;
			ident_q <= cmd.ident;
			class_q <= cmd.token_class;
			type_q  <= cmd.token_type;
			sel_q   <= cmd.scope_sel;
		end
		if (out_load) begin
			out_res_q <= res_q;
			out_lvl_q <= cur_q[0];
		end
	end

	// table memory, one port each way, registered read
	always_ff @(posedge clk) begin
		if (mc.wr_en)
			mem[mc.wr_addr] <= mc.wr_data;
		if (mc.rd_en)
			rd_row_q <= mem[mc.rd_addr];
	end

	assign cmd.ready       = ready;
	assign rsp.valid       = out_valid_q;
	assign rsp.found       = out_res_q.found;
	assign rsp.entry_type  = out_res_q.etype;
	assign rsp.entry_slot  = out_res_q.eslot;
	assign rsp.error       = out_res_q.err;
	assign rsp.scope_level = out_lvl_q;

	// Table is only written by the reset sweep, a pop sweep or an install.
	a_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		mc.wr_en |-> (state_q == ST_CLEAR || state_q == ST_SWEEP
			|| (state_q == ST_RD && kind_q == KIND_INSTALL)))
		else $error("table write outside sweep or install");

	// An accepted word is always dispatched next cycle.
	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready) |=> state_q == ST_DISPATCH)
		else $error("accepted word not dispatched");

	// A result never reports success together with an error code.
	a_found_err: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.found && rsp.error != ERR_NONE))
		else $error("found with error");

	// A completed pop sweep lowers the level by one.
	a_pop_level: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP && state_d == ST_DONE) |=> cur_q == $past(cur_q) - 1'b1)
		else $error("pop did not lower level");

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps

// Checks the scoped symbol table one word at a time. Every command word that
// is accepted runs through a local copy of the table (levels, buckets, ways,
// valid bits and current level). That copy yields the result word the block
// has to return, and the word is queued in order. A monitor pops the queue on
// each accepted result word and compares the fields one by one. A short table
// of directed words comes first. Randomized words follow, aimed at a few busy
// buckets so that hits, duplicates and full buckets occur often.
module testbench;
	import sst_pkg::*;

	localparam int SLOTS        = LEVELS * BUCKETS * WAYS;
	localparam int CYCLE_LIMIT  = 600000;       // watchdog limit, in clock cycles
	localparam int TAIL_CYCLES  = BUCKETS + 64; // a pop sweeps a whole level
	localparam int RANDOM_WORDS = 400;

	// kinds with no function; the block answers them with an empty word
	localparam logic [2:0] KIND_SPARE_LO = 3'd5;
	localparam logic [2:0] KIND_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] ident;
		logic [5:0]  tclass;
		logic [7:0]  ttype;
		logic [1:0]  sel;
	} sym_cmd_t;

	typedef struct packed {
		logic        found;
		logic [7:0]  etype;
		logic [10:0] eslot;
		logic [2:0]  err;
		logic        level;
	} sym_res_t;

	typedef struct {
		sym_cmd_t c;
		bit       typed;   // result below is typed in, not taken from the predictor
		sym_res_t r;
	} plan_row_t;

	logic clk;
	logic arst_n;

	sst_cmd_if cmd_bus ();
	sst_rsp_if rsp_bus ();

	scoped_symbol_table dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus),
		.rsp    (rsp_bus)
	);

	// ---------------------------------------------------------------
	// Local copy of the symbol table
	// ---------------------------------------------------------------
	logic [15:0] tab_ident [SLOTS];
	logic [5:0]  tab_class [SLOTS];
	logic [7:0]  tab_type  [SLOTS];
	bit          tab_live  [SLOTS];
	int          scope_now;

	sym_res_t  pending [$];   // result words still owed by the block, oldest first
	plan_row_t plan [$];      // directed words

	int cycle_cnt;
	int fault_cnt;
	int words_sent;
	int words_seen;
	int n_lookup, n_install, n_scope, n_hit;
	int err_seen [8];
	int burst_left;

	// Slot of the key at one level, -1 on a miss. Ways are scanned from 0,
	// so the lowest way that matches wins.
	function automatic int find_in_level(int lvl, int bkt, logic [15:0] id, logic [5:0] cls);
		int base;
		base = (lvl * BUCKETS + bkt) * WAYS;
		for (int w = 0; w < WAYS; w++)
			if (tab_live[base + w] && tab_ident[base + w] == id && tab_class[base + w] == cls)
				return base + w;
		return -1;
	endfunction

	// Applies one command word to the local table and returns the result word.
	// A command that fails leaves the table and the level alone.
	function automatic sym_res_t symtab_step(sym_cmd_t c);
		sym_res_t r;
		int bkt;
		int hit;
		int base;
		int w;
		r = '0;
		hit = -1;
		bkt = c.ident % BUCKETS;
		case (c.kind)
		KIND_LOOKUP_ALL: begin
			// current level first, then each level below it
			for (int l = scope_now; l >= 0 && hit < 0; l--)
				hit = find_in_level(l, bkt, c.ident, c.tclass);
		end
		KIND_LOOKUP_ONE: begin
			if (c.sel >= LEVELS)
				r.err = ERR_SCOPE;
			else
				hit = find_in_level(int'(c.sel), bkt, c.ident, c.tclass);
		end
		KIND_INSTALL: begin
			hit = find_in_level(scope_now, bkt, c.ident, c.tclass);
			if (hit >= 0) begin
				// duplicate: point at the entry that already holds the key
				r.err = ERR_DUP;
				r.etype = tab_type[hit];
				r.eslot = 11'(hit);
				hit = -1;
			end else begin
				base = (scope_now * BUCKETS + bkt) * WAYS;
				w = 0;
				while (w < WAYS && tab_live[base + w])
					w++;
				if (w == WAYS) begin
					r.err = ERR_FULL;
				end else begin
					tab_ident[base + w] = c.ident;
					tab_class[base + w] = c.tclass;
					tab_type[base + w] = c.ttype;
					tab_live[base + w] = 1'b1;
					r.found = 1'b1;
					r.etype = c.ttype;
					r.eslot = 11'(base + w);
				end
			end
		end
		KIND_PUSH: begin
			if (scope_now + 1 >= LEVELS)
				r.err = ERR_OVER;
			else
				scope_now++;
		end
		KIND_POP: begin
			if (scope_now == 0) begin
				r.err = ERR_UNDER;
			end else begin
				for (int s = scope_now * BUCKETS * WAYS; s < (scope_now + 1) * BUCKETS * WAYS; s++)
					tab_live[s] = 1'b0;
				scope_now--;
			end
		end
		default: ;
		endcase
		if (hit >= 0) begin
			r.found = 1'b1;
			r.etype = tab_type[hit];
			r.eslot = 11'(hit);
		end
		r.level = 1'(scope_now);
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	task automatic add_row(input logic [2:0] kind, input logic [15:0] ident,
		input logic [5:0] tclass, input logic [7:0] ttype, input logic [1:0] sel,
		input bit typed, input logic found, input logic [7:0] etype,
		input logic [10:0] eslot, input logic [2:0] err, input logic level);
		plan_row_t row;
		row.c = '{kind, ident, tclass, ttype, sel};
		row.typed = typed;
		row.r = '{found, etype, eslot, err, level};
		plan.push_back(row);
	endtask

	// Random word. Most keys land in four busy buckets with a handful of
	// identifiers and classes, so installs collide and buckets fill up.
	function automatic sym_cmd_t rand_cmd();
		sym_cmd_t c;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 30)
			c.kind = KIND_LOOKUP_ALL;
		else if (pick < 45)
			c.kind = KIND_LOOKUP_ONE;
		else if (pick < 80)
			c.kind = KIND_INSTALL;
		else if (pick < 88)
			c.kind = KIND_PUSH;
		else if (pick < 95)
			c.kind = KIND_POP;
		else
			c.kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
		if ($urandom_range(0, 3) == 0) begin
			c.ident = 16'($urandom);
		end else begin
			c.ident[15:8] = ($urandom_range(0, 9) == 0) ? 8'hFF : 8'($urandom_range(0, 5));
			case ($urandom_range(0, 3))
			0: c.ident[7:0] = 8'h00;
			1: c.ident[7:0] = 8'h01;
			2: c.ident[7:0] = 8'h7F;
			default: c.ident[7:0] = 8'hFF;
			endcase
		end
		pick = $urandom_range(0, 9);
		if (pick < 7)
			c.tclass = 6'($urandom_range(0, 1));
		else if (pick == 7)
			c.tclass = 6'h3F;
		else
			c.tclass = 6'($urandom);
		c.ttype = 8'($urandom);
		c.sel = ($urandom_range(0, 4) == 0) ? 2'($urandom_range(2, 3)) : 2'($urandom_range(0, 1));
		return c;
	endfunction

	// Drives one word from a falling edge and holds it until the rising edge
	// that takes it. Returns on the next falling edge with valid still high.
	task automatic send_word(input sym_cmd_t c, input bit typed, input sym_res_t typed_res);
		sym_res_t pred;
		cmd_bus.kind = c.kind;
		cmd_bus.ident = c.ident;
		cmd_bus.token_class = c.tclass;
		cmd_bus.token_type = c.ttype;
		cmd_bus.scope_sel = c.sel;
		cmd_bus.valid = 1'b1;
		do
			@(posedge clk);
		while (cmd_bus.ready !== 1'b1);
		pred = symtab_step(c);
		pending.push_back(typed ? typed_res : pred);
		words_sent++;
		err_seen[pred.err]++;
		if (pred.found && c.kind != KIND_INSTALL)
			n_hit++;
		if (c.kind == KIND_LOOKUP_ALL || c.kind == KIND_LOOKUP_ONE)
			n_lookup++;
		else if (c.kind == KIND_INSTALL)
			n_install++;
		else if (c.kind == KIND_PUSH || c.kind == KIND_POP)
			n_scope++;
		@(negedge clk);
	endtask

	// Bursts of back-to-back words; between bursts a gap, sometimes none.
	task automatic pace_sender();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				cmd_bus.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
	endtask

	// Hold the command side quiet until every owed word has come back.
	task automatic drain_pending();
		cmd_bus.valid = 1'b0;
		while (pending.size() != 0)
			@(negedge clk);
	endtask

	// ---------------------------------------------------------------
	// Checking
	// ---------------------------------------------------------------
	task automatic log_fault(input string msg);
		fault_cnt++;
		if (fault_cnt <= 10)
			$display("[%0t] MISMATCH %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (got !== want)
			log_fault($sformatf("word %0d %s: expected %0d, got %0d", words_seen, name, want, got));
	endtask

	sym_res_t want_res;

	always @(posedge clk) begin
		if (arst_n && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
			if (pending.size() == 0) begin
				log_fault($sformatf("word %0d arrived with nothing outstanding", words_seen));
			end else begin
				want_res = pending.pop_front();
				check_field("found", 16'(want_res.found), 16'(rsp_bus.found));
				check_field("entry_type", 16'(want_res.etype), 16'(rsp_bus.entry_type));
				check_field("entry_slot", 16'(want_res.eslot), 16'(rsp_bus.entry_slot));
				check_field("error", 16'(want_res.err), 16'(rsp_bus.error));
				check_field("scope_level", 16'(want_res.level), 16'(rsp_bus.scope_level));
			end
			words_seen++;
		end
	end

	// watchdog; a hung handshake ends the run here
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d words owed", cycle_cnt, pending.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Clock, reset, receiver
	// ---------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver ready follows the bits of a 16-bit pattern in turn; each new pattern gives
	// no stalls at all, random stalls, or mostly stalled.
	initial begin : rsp_pacer
		logic [15:0] pat;
		int phase;
		rsp_bus.ready = 1'b0;
		pat = '1;
		phase = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (phase % 64 == 0) begin
				case ($urandom_range(0, 2))
				0: pat = '1;
				1: pat = 16'($urandom) | 16'h0001;
				default: pat = 16'($urandom & $urandom) | 16'h0001;
				endcase
			end
			rsp_bus.ready = pat[phase % 16];
			phase++;
		end
	end

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin : stimulus
		arst_n = 1'b0;
		cmd_bus.valid = 1'b0;
		cmd_bus.kind = KIND_LOOKUP_ALL;
		cmd_bus.ident = '0;
		cmd_bus.token_class = '0;
		cmd_bus.token_type = '0;
		cmd_bus.scope_sel = '0;
		scope_now = 0;
		burst_left = 0;

		// kind, ident, class, type, sel | typed, found, etype, eslot, error, level
		// empty table: miss, bad scope at both out-of-range levels, pop at level 0
		add_row(KIND_LOOKUP_ALL, 16'h0000, 6'h00, 8'h00, 2'd0, 1, 0, 8'h00, 11'd0, ERR_NONE, 0);
		add_row(KIND_LOOKUP_ONE, 16'h0000, 6'h00, 8'h00, 2'd2, 1, 0, 8'h00, 11'd0, ERR_SCOPE, 0);
		add_row(KIND_LOOKUP_ONE, 16'hFFFF, 6'h3F, 8'hFF, 2'd3, 1, 0, 8'h00, 11'd0, ERR_SCOPE, 0);
		add_row(KIND_POP,        16'h0000, 6'h00, 8'h00, 2'd0, 1, 0, 8'h00, 11'd0, ERR_UNDER, 0);
		// first and last bucket, then a duplicate that names the old entry
		add_row(KIND_INSTALL,    16'h0000, 6'h00, 8'h00, 2'd0, 1, 1, 8'h00, 11'd0, ERR_NONE, 0);
		add_row(KIND_INSTALL,    16'hFFFF, 6'h3F, 8'hFF, 2'd0, 1, 1, 8'hFF, 11'd1020, ERR_NONE, 0);
		add_row(KIND_INSTALL,    16'h0000, 6'h00, 8'h55, 2'd0, 1, 0, 8'h00, 11'd0, ERR_DUP, 0);
		// fill bucket 0 to its lowest free ways, then overflow it
		add_row(KIND_INSTALL,    16'h0100, 6'h00, 8'h01, 2'd0, 1, 1, 8'h01, 11'd1, ERR_NONE, 0);
		add_row(KIND_INSTALL,    16'h0200, 6'h00, 8'h02, 2'd0, 1, 1, 8'h02, 11'd2, ERR_NONE, 0);
		add_row(KIND_INSTALL,    16'h0300, 6'h05, 8'h03, 2'd0, 0, 0, 8'h00, 11'd0, ERR_NONE, 0);
		add_row(KIND_INSTALL,    16'h0400, 6'h00, 8'h04, 2'd0, 1, 0, 8'h00, 11'd0, ERR_FULL, 0);
		// class is part of the key
		add_row(KIND_LOOKUP_ALL, 16'h0200, 6'h00, 8'h00, 2'd0, 1, 1, 8'h02, 11'd2, ERR_NONE, 0);
		add_row(KIND_LOOKUP_ALL, 16'h0200, 6'h01, 8'h00, 2'd0, 1, 0, 8'h00, 11'd0, ERR_NONE, 0);
		// raise the level, then push past the top
		add_row(KIND_PUSH,       16'h0000, 6'h00, 8'h00, 2'd0, 1, 0, 8'h00, 11'd0, ERR_NONE, 1);
		add_row(KIND_PUSH,       16'h0000, 6'h00, 8'h00, 2'd0, 1, 0, 8'h00, 11'd0, ERR_OVER, 1);
		// falls through to level 0, then a shadowing entry at level 1
		add_row(KIND_LOOKUP_ALL, 16'h0000, 6'h00, 8'h00, 2'd0, 1, 1, 8'h00, 11'd0, ERR_NONE, 1);
		add_row(KIND_INSTALL,    16'h0000, 6'h00, 8'hAA, 2'd0, 1, 1, 8'hAA, 11'd1024, ERR_NONE, 1);
		add_row(KIND_LOOKUP_ALL, 16'h0000, 6'h00, 8'h00, 2'd0, 1, 1, 8'hAA, 11'd1024, ERR_NONE, 1);
		add_row(KIND_LOOKUP_ONE, 16'h0000, 6'h00, 8'h00, 2'd0, 1, 1, 8'h00, 11'd0, ERR_NONE, 1);
		add_row(KIND_LOOKUP_ONE, 16'h0000, 6'h00, 8'h00, 2'd1, 1, 1, 8'hAA, 11'd1024, ERR_NONE, 1);
		// spare kinds do nothing
		add_row(KIND_SPARE_LO,   16'h0000, 6'h00, 8'h00, 2'd0, 1, 0, 8'h00, 11'd0, ERR_NONE, 1);
		add_row(KIND_SPARE_HI,   16'hFFFF, 6'h3F, 8'hFF, 2'd3, 1, 0, 8'h00, 11'd0, ERR_NONE, 1);
		// pop clears level 1
		add_row(KIND_POP,        16'h0000, 6'h00, 8'h00, 2'd0, 1, 0, 8'h00, 11'd0, ERR_NONE, 0);
		add_row(KIND_LOOKUP_ONE, 16'h0000, 6'h00, 8'h00, 2'd1, 1, 0, 8'h00, 11'd0, ERR_NONE, 0);
		add_row(KIND_LOOKUP_ALL, 16'hFFFF, 6'h3F, 8'h00, 2'd0, 0, 0, 8'h00, 11'd0, ERR_NONE, 0);

		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// first word waits out the clearing sweep on cmd.ready
		foreach (plan[i]) begin
			send_word(plan[i].c, plan[i].typed, plan[i].r);
			pace_sender();
		end
		drain_pending();

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			send_word(rand_cmd(), 1'b0, '0);
			if (i % 100 == 99)
				drain_pending();
			else
				pace_sender();
		end

		drain_pending();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (pending.size() != 0)
			log_fault($sformatf("%0d result words never arrived", pending.size()));

		$display("Covered %0d command words (%0d lookups, %0d installs, %0d push/pop), %0d results",
			words_sent, n_lookup, n_install, n_scope, words_seen);
		$display("Lookup hits %0d; dup %0d, full %0d, overflow %0d, underflow %0d, bad scope %0d",
			n_hit, err_seen[ERR_DUP], err_seen[ERR_FULL], err_seen[ERR_OVER],
			err_seen[ERR_UNDER], err_seen[ERR_SCOPE]);
		if (fault_cnt == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches in total", fault_cnt);
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
